// ----- design/assert_macros.svh -----
// Assertion macros for the design files; only the slot table module uses them.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UST_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define UST_ASSERT_IMPL(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("%m: check failed");
`define UST_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("%m: check failed");
`else
`define UST_ASSERT(lbl, clk, rst, prop)
`define UST_ASSERT_IMPL(lbl, clk, rst, a, b)
`define UST_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

// ----- design/ust_pkg.sv -----
// Package for the unique slot table: op codes, register indexes, entry type
// and the xorshift32 step. No dependencies.
`default_nettype none
package ust_pkg;

  localparam int ID_BITS    = 16;
  localparam int OWNER_BITS = 4;
  localparam int ROLL_BITS  = 32;

  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_ASSIGN  = 3'd1;
  localparam logic [2:0] OP_AOS     = 3'd2;
  localparam logic [2:0] OP_SWAP    = 3'd3;
  localparam logic [2:0] OP_SHUFFLE = 3'd4;
  localparam logic [2:0] OP_POOL    = 3'd5;
  localparam logic [2:0] OP_READ    = 3'd6;

  localparam logic [1:0] REG_SLOT_COUNT  = 2'd0;
  localparam logic [1:0] REG_OWNER_COUNT = 2'd1;
  localparam logic [1:0] REG_SEED        = 2'd2;

  localparam int SH_A = 13;
  localparam int SH_B = 17;
  localparam int SH_C = 5;

  typedef struct packed {
    logic [OWNER_BITS-1:0] owner;
    logic [ID_BITS-1:0]    id;
  } entry_t;

  function automatic logic [ROLL_BITS-1:0] xs32(input logic [ROLL_BITS-1:0] x);
    logic [ROLL_BITS-1:0] y;
    y = (x == '0) ? ROLL_BITS'(1) : x;
    y = y ^ (y << SH_A);
    y = y ^ (y >> SH_B);
    y = y ^ (y << SH_C);
    return y;
  endfunction

endpackage
`default_nettype wire

// ----- design/unique_slot_table_with_shuffle.sv -----
// Unique slot table with shuffle: complete block, one sequencer around a
// table memory, a pool memory and a shared bit-serial modulo unit.
// Depends on ust_pkg and assert_macros.svh.
//
// Use: an op beat is taken on in_valid with in_stall low; in_stall stays high
// while the sequencer works. Every op gives one result beat on out_valid,
// held until out_stall is low; the next op may be taken while it waits.
// Configuration beats (cfg_valid, cfg_ready always high) take effect at clear.
// Every op ends with a recount of the active slots, read one slot at a time
// because the table has one read port. Shuffle adds per step a modulo on
// the shared modulo unit and a swap. A pool entry scans the buffered entries;
// the last entry adds a check of each pool entry against the table, the pool
// shuffle steps and the fill of the empty slots.
// One op is in work at a time.
// Reset: empty table, slot 0 tagged 1, two active slots, seed 1, empty pool.
`default_nettype none
`include "assert_macros.svh"
module unique_slot_table_with_shuffle #(
  parameter int MAX_SLOTS  = 32,
  parameter int MAX_OWNERS = 8,
  parameter int MAX_POOL   = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  op,
  input  wire logic [4:0]  slot,
  input  wire logic [4:0]  second_slot,
  input  wire logic [15:0] team_id,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             ok,
  output logic [5:0]       assigned_count,
  output logic             ready_res,
  output logic [15:0]      slot_team,
  output logic [3:0]       slot_owner,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int TI = $clog2(MAX_SLOTS);
  localparam int AW = $clog2(MAX_SLOTS + 1);
  localparam int PI = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int PW = $clog2(MAX_POOL + 1);
  localparam int XW = (AW > PW) ? AW : PW;
  localparam int OW = $clog2(MAX_OWNERS + 1);
  localparam int IB = ust_pkg::ID_BITS;
  localparam int RB = ust_pkg::ROLL_BITS;

  localparam logic [5:0] S_IDLE    = 6'd0;
  localparam logic [5:0] S_TS_RD   = 6'd1;
  localparam logic [5:0] S_TS_CHK  = 6'd2;
  localparam logic [5:0] S_TS_END  = 6'd3;
  localparam logic [5:0] S_A_WR    = 6'd4;
  localparam logic [5:0] S_B_RDF   = 6'd5;
  localparam logic [5:0] S_B_WRF   = 6'd6;
  localparam logic [5:0] S_B_WRS   = 6'd7;
  localparam logic [5:0] S_SW_A    = 6'd8;
  localparam logic [5:0] S_SW_B    = 6'd9;
  localparam logic [5:0] S_SW_C    = 6'd10;
  localparam logic [5:0] S_SW_D    = 6'd11;
  localparam logic [5:0] S_RD_ISS  = 6'd12;
  localparam logic [5:0] S_RD_OUT  = 6'd13;
  localparam logic [5:0] S_SH_LOOP = 6'd14;
  localparam logic [5:0] S_DIV     = 6'd15;
  localparam logic [5:0] S_DIV_END = 6'd16;
  localparam logic [5:0] S_PS_RD   = 6'd17;
  localparam logic [5:0] S_PS_CHK  = 6'd18;
  localparam logic [5:0] S_PS_END  = 6'd19;
  localparam logic [5:0] S_F_START = 6'd20;
  localparam logic [5:0] S_F_RD    = 6'd21;
  localparam logic [5:0] S_F_HOLD  = 6'd22;
  localparam logic [5:0] S_F_TRD   = 6'd23;
  localparam logic [5:0] S_F_TCHK  = 6'd24;
  localparam logic [5:0] S_F_KEEP  = 6'd25;
  localparam logic [5:0] S_F_MISS  = 6'd26;
  localparam logic [5:0] S_PW_A    = 6'd27;
  localparam logic [5:0] S_PW_B    = 6'd28;
  localparam logic [5:0] S_PW_C    = 6'd29;
  localparam logic [5:0] S_PW_D    = 6'd30;
  localparam logic [5:0] S_FL_RD   = 6'd31;
  localparam logic [5:0] S_FL_CHK  = 6'd32;
  localparam logic [5:0] S_FL_WR   = 6'd33;
  localparam logic [5:0] S_F_END   = 6'd34;
  localparam logic [5:0] S_CN_INIT = 6'd35;
  localparam logic [5:0] S_CN_RD   = 6'd36;
  localparam logic [5:0] S_CN_CHK  = 6'd37;
  localparam logic [5:0] S_DONE    = 6'd38;

  logic [5:0]  state;
  logic [5:0]  cfg_sc;
  logic [3:0]  cfg_oc;
  logic [31:0] cfg_seed;

  logic [AW-1:0] active;
  logic [OW-1:0] own_lim;
  logic [AW-1:0] cnt;
  logic [RB-1:0] rng;
  logic [PW-1:0] pool_n;
  logic          ovf;
  logic [MAX_SLOTS-1:0] vld;

  logic [2:0]    op_r;
  logic [4:0]    sa;
  logic [IB-1:0] idr;
  logic          last_r;
  logic          ok_r;
  logic          found;
  logic          pmode;
  logic [TI-1:0] fidx;
  logic [XW-1:0] i;
  logic [AW-1:0] j;
  logic [PW-1:0] k;
  logic [PW-1:0] nx;
  logic [AW-1:0] c;
  logic [XW-1:0] xa;
  logic [XW-1:0] xb;
  logic [IB-1:0] pv;
  ust_pkg::entry_t ea;
  logic [IB-1:0] rteam;
  logic [3:0]    rowner;

  logic [XW-1:0] dvs;
  logic [XW-1:0] rem;
  logic [RB-1:0] dq;
  logic [4:0]    dcnt;
  logic [XW:0]   dtry;
  logic [XW:0]   dsub;
  logic [XW-1:0] rem_next;

  ust_pkg::entry_t tbl_mem [MAX_SLOTS];
  ust_pkg::entry_t tbl_q;
  logic            vld_q;
  logic [TI-1:0]   tbl_qidx;
  ust_pkg::entry_t tbl_ent;
  logic [3:0]      dflt_owner;
  logic [TI-1:0]   tbl_raddr;
  logic            tbl_we;
  logic [TI-1:0]   tbl_waddr;
  ust_pkg::entry_t tbl_wdata;

  logic [IB-1:0] pool_mem [MAX_POOL];
  logic [IB-1:0] pool_q;
  logic [PI-1:0] pool_raddr;
  logic          pool_we;
  logic [PI-1:0] pool_waddr;
  logic [IB-1:0] pool_wdata;

  logic          accept;
  logic          s_ok;
  logic          s2_ok;
  logic [AW-1:0] clr_active;
  logic [OW-1:0] clr_own;
  logic [RB-1:0] roll;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign s_ok      = int'(slot) < int'(active);
  assign s2_ok     = int'(second_slot) < int'(active);
  assign roll      = ust_pkg::xs32(rng);

  always_comb begin
    int n;
    int lim;
    int p;
    n = int'(cfg_sc);
    if (n < 2) n = 2;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    lim = (n < MAX_OWNERS) ? n : MAX_OWNERS;
    p = int'(cfg_oc);
    if (p < 1) p = 1;
    if (p > lim) p = lim;
    clr_active = AW'(n);
    clr_own    = OW'(p);
  end

  assign dflt_owner = (int'(tbl_qidx) < int'(own_lim)) ? 4'(int'(tbl_qidx) + 1) : 4'd0;
  assign tbl_ent    = vld_q ? tbl_q : ust_pkg::entry_t'{owner: dflt_owner, id: '0};

  assign dtry     = {rem, dq[RB-1]};
  assign dsub     = dtry - {1'b0, dvs};
  assign rem_next = (dtry >= {1'b0, dvs}) ? dsub[XW-1:0] : dtry[XW-1:0];

  always_comb begin
    tbl_raddr  = '0;
    tbl_we     = 1'b0;
    tbl_waddr  = '0;
    tbl_wdata  = tbl_ent;
    pool_raddr = '0;
    pool_we    = 1'b0;
    pool_waddr = '0;
    pool_wdata = idr;
    unique case (state)
      S_TS_RD, S_CN_RD, S_FL_RD: tbl_raddr = i[TI-1:0];
      S_TS_END, S_RD_ISS: tbl_raddr = TI'(sa);
      S_B_RDF: tbl_raddr = fidx;
      S_SW_A: tbl_raddr = xa[TI-1:0];
      S_SW_B: tbl_raddr = xb[TI-1:0];
      S_F_TRD: tbl_raddr = j[TI-1:0];
      S_A_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = TI'(sa);
        tbl_wdata = ust_pkg::entry_t'{owner: tbl_ent.owner, id: idr};
      end
      S_B_WRF: begin
        tbl_we    = 1'b1;
        tbl_waddr = fidx;
        tbl_wdata = ust_pkg::entry_t'{owner: tbl_ent.owner, id: ea.id};
      end
      S_B_WRS: begin
        tbl_we    = 1'b1;
        tbl_waddr = TI'(sa);
        tbl_wdata = ust_pkg::entry_t'{owner: ea.owner, id: idr};
      end
      S_SW_C: begin
        tbl_we    = 1'b1;
        tbl_waddr = xa[TI-1:0];
        tbl_wdata = tbl_ent;
      end
      S_SW_D: begin
        tbl_we    = 1'b1;
        tbl_waddr = xb[TI-1:0];
        tbl_wdata = ea;
      end
      S_FL_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = i[TI-1:0];
        tbl_wdata = ust_pkg::entry_t'{owner: ea.owner, id: pool_q};
      end
      S_PS_RD, S_F_RD: pool_raddr = i[PI-1:0];
      S_PW_A: pool_raddr = xa[PI-1:0];
      S_PW_B: pool_raddr = xb[PI-1:0];
      S_FL_CHK: pool_raddr = nx[PI-1:0];
      S_PS_END: begin
        pool_we    = !(found || idr == '0) && (int'(pool_n) < MAX_POOL);
        pool_waddr = pool_n[PI-1:0];
        pool_wdata = idr;
      end
      S_F_KEEP: begin
        pool_we    = !found;
        pool_waddr = k[PI-1:0];
        pool_wdata = pv;
      end
      S_PW_C: begin
        pool_we    = 1'b1;
        pool_waddr = xa[PI-1:0];
        pool_wdata = pool_q;
      end
      S_PW_D: begin
        pool_we    = 1'b1;
        pool_waddr = xb[PI-1:0];
        pool_wdata = pv;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_q    <= tbl_mem[tbl_raddr];
    vld_q    <= vld[tbl_raddr];
    tbl_qidx <= tbl_raddr;
  end

  always_ff @(posedge clk) begin
    if (pool_we) pool_mem[pool_waddr] <= pool_wdata;
    pool_q <= pool_mem[pool_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cfg_sc    <= 6'd2;
      cfg_oc    <= 4'd1;
      cfg_seed  <= 32'd1;
      active    <= AW'(2);
      own_lim   <= OW'(1);
      cnt       <= '0;
      rng       <= RB'(1);
      pool_n    <= '0;
      ovf       <= 1'b0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ust_pkg::REG_SLOT_COUNT:  cfg_sc   <= cfg_data[5:0];
          ust_pkg::REG_OWNER_COUNT: cfg_oc   <= cfg_data[3:0];
          ust_pkg::REG_SEED:        cfg_seed <= cfg_data;
          default: begin
          end
        endcase
      end
      if (tbl_we) vld[tbl_waddr] <= 1'b1;
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_r   <= op;
            sa     <= slot;
            idr    <= team_id;
            last_r <= last;
            rteam  <= '0;
            rowner <= '0;
            found  <= 1'b0;
            i      <= (op == ust_pkg::OP_SHUFFLE) ? XW'(active) : '0;
            unique case (op)
              ust_pkg::OP_CLEAR: begin
                active  <= clr_active;
                own_lim <= clr_own;
                vld     <= '0;
                rng     <= (cfg_seed == '0) ? RB'(1) : cfg_seed;
                pool_n  <= '0;
                ovf     <= 1'b0;
                ok_r    <= 1'b1;
                state   <= S_CN_INIT;
              end
              ust_pkg::OP_ASSIGN, ust_pkg::OP_AOS: begin
                ok_r  <= 1'b0;
                state <= (s_ok && team_id != '0) ? S_TS_RD : S_CN_INIT;
              end
              ust_pkg::OP_SWAP: begin
                xa    <= XW'(slot);
                xb    <= XW'(second_slot);
                ok_r  <= s_ok && s2_ok;
                state <= (s_ok && s2_ok) ? S_SW_A : S_CN_INIT;
              end
              ust_pkg::OP_SHUFFLE: begin
                ok_r  <= (cnt == active);
                pmode <= 1'b0;
                state <= (cnt == active) ? S_SH_LOOP : S_CN_INIT;
              end
              ust_pkg::OP_POOL: begin
                ok_r  <= 1'b0;
                state <= S_PS_RD;
              end
              ust_pkg::OP_READ: begin
                ok_r  <= 1'b0;
                state <= s_ok ? S_RD_ISS : S_CN_INIT;
              end
              default: begin
                ok_r  <= 1'b0;
                state <= S_CN_INIT;
              end
            endcase
          end
        end
        S_TS_RD: state <= (int'(i) == int'(active)) ? S_TS_END : S_TS_CHK;
        S_TS_CHK: begin
          if (int'(i) != int'(sa) && tbl_ent.id == idr && !found) begin
            found <= 1'b1;
            fidx  <= i[TI-1:0];
          end
          i     <= i + XW'(1);
          state <= S_TS_RD;
        end
        S_TS_END: begin
          if (op_r == ust_pkg::OP_ASSIGN) state <= found ? S_CN_INIT : S_A_WR;
          else state <= S_B_RDF;
        end
        S_A_WR: begin
          ok_r  <= 1'b1;
          state <= S_CN_INIT;
        end
        S_B_RDF: begin
          ea    <= tbl_ent;
          state <= found ? S_B_WRF : S_B_WRS;
        end
        S_B_WRF: state <= S_B_WRS;
        S_B_WRS: begin
          ok_r  <= 1'b1;
          state <= S_CN_INIT;
        end
        S_SW_A: state <= S_SW_B;
        S_SW_B: begin
          ea    <= tbl_ent;
          state <= S_SW_C;
        end
        S_SW_C: state <= S_SW_D;
        S_SW_D: begin
          if (op_r == ust_pkg::OP_SWAP) begin
            state <= S_CN_INIT;
          end else begin
            i     <= i - XW'(1);
            state <= S_SH_LOOP;
          end
        end
        S_RD_ISS: state <= S_RD_OUT;
        S_RD_OUT: begin
          rteam  <= tbl_ent.id;
          rowner <= tbl_ent.owner;
          ok_r   <= 1'b1;
          state  <= S_CN_INIT;
        end
        S_SH_LOOP: begin
          if (i < XW'(2)) begin
            if (pmode) begin
              i     <= '0;
              nx    <= '0;
              state <= S_FL_RD;
            end else begin
              state <= S_CN_INIT;
            end
          end else begin
            rng   <= roll;
            dq    <= roll;
            rem   <= '0;
            dvs   <= i;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= rem_next;
          dq   <= dq << 1;
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd31) state <= S_DIV_END;
        end
        S_DIV_END: begin
          xa    <= i - XW'(1);
          xb    <= rem;
          state <= pmode ? S_PW_A : S_SW_A;
        end
        S_PS_RD: state <= (int'(i) == int'(pool_n)) ? S_PS_END : S_PS_CHK;
        S_PS_CHK: begin
          if (pool_q == idr) found <= 1'b1;
          i     <= i + XW'(1);
          state <= S_PS_RD;
        end
        S_PS_END: begin
          if (!(found || idr == '0) && int'(pool_n) >= MAX_POOL) begin
            ovf  <= 1'b1;
            ok_r <= 1'b0;
          end else begin
            ok_r <= 1'b1;
            if (!(found || idr == '0)) pool_n <= pool_n + PW'(1);
          end
          state <= last_r ? S_F_START : S_CN_INIT;
        end
        S_F_START: begin
          i <= '0;
          k <= '0;
          if (ovf) begin
            ok_r  <= 1'b0;
            state <= S_F_END;
          end else begin
            state <= S_F_RD;
          end
        end
        S_F_RD: state <= (int'(i) == int'(pool_n)) ? S_F_MISS : S_F_HOLD;
        S_F_HOLD: begin
          pv    <= pool_q;
          found <= 1'b0;
          j     <= '0;
          state <= S_F_TRD;
        end
        S_F_TRD: state <= (j == active) ? S_F_KEEP : S_F_TCHK;
        S_F_TCHK: begin
          if (tbl_ent.id == pv) found <= 1'b1;
          j     <= j + AW'(1);
          state <= S_F_TRD;
        end
        S_F_KEEP: begin
          if (!found) k <= k + PW'(1);
          i     <= i + XW'(1);
          state <= S_F_RD;
        end
        S_F_MISS: begin
          if (int'(k) >= int'(active) - int'(cnt)) begin
            ok_r  <= 1'b1;
            i     <= XW'(k);
            pmode <= 1'b1;
            state <= S_SH_LOOP;
          end else begin
            ok_r  <= 1'b0;
            state <= S_F_END;
          end
        end
        S_PW_A: state <= S_PW_B;
        S_PW_B: begin
          pv    <= pool_q;
          state <= S_PW_C;
        end
        S_PW_C: state <= S_PW_D;
        S_PW_D: begin
          i     <= i - XW'(1);
          state <= S_SH_LOOP;
        end
        S_FL_RD: state <= (int'(i) == int'(active)) ? S_F_END : S_FL_CHK;
        S_FL_CHK: begin
          ea <= tbl_ent;
          if (tbl_ent.id == '0 && nx < k) begin
            state <= S_FL_WR;
          end else begin
            i     <= i + XW'(1);
            state <= S_FL_RD;
          end
        end
        S_FL_WR: begin
          nx    <= nx + PW'(1);
          i     <= i + XW'(1);
          state <= S_FL_RD;
        end
        S_F_END: begin
          pool_n <= '0;
          ovf    <= 1'b0;
          state  <= S_CN_INIT;
        end
        S_CN_INIT: begin
          i     <= '0;
          c     <= '0;
          state <= S_CN_RD;
        end
        S_CN_RD: state <= (int'(i) == int'(active)) ? S_DONE : S_CN_CHK;
        S_CN_CHK: begin
          if (tbl_ent.id != '0) c <= c + AW'(1);
          i     <= i + XW'(1);
          state <= S_CN_RD;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            ok             <= ok_r;
            assigned_count <= 6'(c);
            ready_res      <= (c == active);
            slot_team      <= rteam;
            slot_owner     <= rowner;
            cnt            <= c;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `UST_ASSERT(a_pool_bound, clk, rst, int'(pool_n) <= MAX_POOL)
  `UST_ASSERT_IMPL(a_count_bound, clk, rst, state == S_IDLE, cnt <= active)
  `UST_ASSERT_IMPL(a_div_operand, clk, rst, state == S_DIV, dvs >= XW'(2))
  `UST_ASSERT_NEXT(a_busy_after_beat, clk, rst, accept, state != S_IDLE)
  `UST_ASSERT_NEXT(a_hold_result, clk, rst, state == S_DONE && out_valid && out_stall,
                   state == S_DONE)

endmodule
`default_nettype wire
